[rtl/core/sem_pkg.sv]
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  localparam int LUMA_WR    = 30;
  localparam int LUMA_WG    = 59;
  localparam int LUMA_WB    = 11;
  localparam int LUMA_RECIP = 5243;
  localparam int LUMA_SHIFT = 19;

  localparam int KERN_X [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
  localparam int KERN_Y [9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [7:0] luma_t;

  typedef struct packed {
    luma_t [8:0] tap;
    logic        last;
  } nbhd_t;

endpackage

`default_nettype wire

[rtl/core/sem_queue.sv]
// ----------------------------------------------------------------------------
// sem_queue
// Small FIFO of 3x3 neighborhoods between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_queue #(
  parameter int DEPTH = sem_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sem_pkg::nbhd_t push_data,
  output logic          full,
  input  logic          pop,
  output sem_pkg::nbhd_t pop_data,
  output logic          empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sem_pkg::nbhd_t    entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sem_front.sv]
// ----------------------------------------------------------------------------
// sem_front
// Pixel intake: raster position tracking, result classification, luma,
// row buffer and 3x3 window; pushes clamped neighborhoods into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_front #(
  parameter  int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF,
  localparam int COL_W     = $clog2(MAX_WIDTH),
  localparam int WID_W     = $clog2(MAX_WIDTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               restart,
  input  logic [WID_W-1:0]   width_eff,
  input  logic [15:0]        height_eff,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  output logic               q_push,
  output sem_pkg::nbhd_t     q_data,
  input  logic               q_full
);

  localparam logic [1:0] ROW_FIRST  = 2'd0;
  localparam logic [1:0] ROW_SECOND = 2'd1;
  localparam logic [1:0] ROW_LATER  = 2'd2;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             emit;
    logic             last;
    logic             col_zero;
    logic             left_cl;
    logic             top_cl;
    logic             bot_cl;
  } s1_ctl_t;

  logic              accept;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [1:0]        in_row_r, in_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [15:0]       out_row_r, out_row_nxt;

  logic [COL_W-1:0]  col;
  logic              col_zero;
  logic              row_wrap;
  logic              col_end;
  logic              bot_edge;
  logic              emit;
  logic              last;
  logic [14:0]       wsum;

  logic              s1_vld_r;
  s1_ctl_t           s1_ctl_r;
  logic [14:0]       wsum_r;
  logic              fwd_r;
  logic [15:0]       rd_pair_r;
  logic [15:0]       wr_pair_r;
  logic              s1_adv;

  logic [15:0]       row_mem [MAX_WIDTH];

  logic [15:0]       pair;
  logic [27:0]       luma_prod;
  sem_pkg::luma_t    luma;
  sem_pkg::luma_t    newcol [3];
  sem_pkg::luma_t    lv [3];
  sem_pkg::luma_t    mv [3];
  sem_pkg::luma_t    rv [3];
  sem_pkg::luma_t    win_r [9];
  sem_pkg::luma_t    win_nxt [9];

  assign s1_adv   = s1_vld_r && (!s1_ctl_r.emit || !q_full);
  assign in_stall = s1_vld_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    col      = (WID_W'(in_col_r) >= width_eff) ? '0 : in_col_r;
    col_zero = (col == '0);
    row_wrap = (WID_W'(col) + WID_W'(1)) >= width_eff;
    col_end  = (WID_W'(out_col_r) + WID_W'(1)) >= width_eff;
    bot_edge = ({1'b0, out_row_r} + 17'd1) >= {1'b0, height_eff};
    emit     = ((in_row_r == ROW_LATER) || ((in_row_r == ROW_SECOND) && !col_zero))
               && (out_row_r < height_eff);
    last     = emit && bot_edge && col_end;
    if (sem_pkg::opcode_t'(in_opcode) == sem_pkg::OP_PIXEL) begin
      wsum = 15'(sem_pkg::LUMA_WR) * 15'(in_red)
           + 15'(sem_pkg::LUMA_WG) * 15'(in_green)
           + 15'(sem_pkg::LUMA_WB) * 15'(in_blue);
    end else begin
      wsum = '0;
    end
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (restart || (accept && last)) begin
      in_col_nxt  = '0;
      in_row_nxt  = ROW_FIRST;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (accept) begin
      in_col_nxt = row_wrap ? '0 : col + COL_W'(1);
      if (row_wrap && (in_row_r != ROW_LATER)) begin
        in_row_nxt = in_row_r + 2'd1;
      end
      if (emit) begin
        out_col_nxt = col_end ? '0 : out_col_r + COL_W'(1);
        if (col_end) begin
          out_row_nxt = out_row_r + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= ROW_FIRST;
      out_col_r <= '0;
      out_row_r <= '0;
      s1_vld_r  <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      s1_vld_r  <= accept || (s1_vld_r && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r <= '{col: col, emit: emit, last: last, col_zero: col_zero,
                    left_cl: (out_col_r == '0), top_cl: (out_row_r == '0),
                    bot_cl: bot_edge};
      wsum_r   <= wsum;
      fwd_r    <= s1_adv && (col == s1_ctl_r.col);
    end
    if (s1_adv) begin
      wr_pair_r <= {pair[7:0], luma};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      row_mem[s1_ctl_r.col] <= {pair[7:0], luma};
    end
    if (accept) begin
      rd_pair_r <= row_mem[col];
    end
  end

  always_comb begin
    pair      = fwd_r ? wr_pair_r : rd_pair_r;
    luma_prod = 28'(wsum_r) * 28'(sem_pkg::LUMA_RECIP);
    luma      = luma_prod[sem_pkg::LUMA_SHIFT +: 8];
    newcol[0] = pair[15:8];
    newcol[1] = pair[7:0];
    newcol[2] = luma;
    for (int r = 0; r < 3; r++) begin
      lv[r] = s1_ctl_r.left_cl ? win_r[r*3+2] : win_r[r*3+1];
      mv[r] = win_r[r*3+2];
      rv[r] = s1_ctl_r.col_zero ? win_r[r*3+2] : newcol[r];
      win_nxt[r*3+0] = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
      win_nxt[r*3+2] = newcol[r];
    end
    q_data.tap[0] = s1_ctl_r.top_cl ? lv[1] : lv[0];
    q_data.tap[1] = s1_ctl_r.top_cl ? mv[1] : mv[0];
    q_data.tap[2] = s1_ctl_r.top_cl ? rv[1] : rv[0];
    q_data.tap[3] = lv[1];
    q_data.tap[4] = mv[1];
    q_data.tap[5] = rv[1];
    q_data.tap[6] = s1_ctl_r.bot_cl ? lv[1] : lv[2];
    q_data.tap[7] = s1_ctl_r.bot_cl ? mv[1] : mv[2];
    q_data.tap[8] = s1_ctl_r.bot_cl ? rv[1] : rv[2];
    q_data.last   = s1_ctl_r.last;
  end

  assign q_push = s1_adv && s1_ctl_r.emit;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else if (s1_adv) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= s1_ctl_r.last ? '0 : win_nxt[k];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/sem_back.sv]
// ----------------------------------------------------------------------------
// sem_back
// Gradient, squared magnitude and pipelined integer square root with
// rounding and saturation; drives the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  sem_pkg::nbhd_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_magnitude,
  output logic           out_last
);

  localparam int          SQ_STEPS  = 8;
  localparam logic [20:0] SAT_LIMIT = 21'd65281;

  typedef struct packed {
    logic [7:0]  q;
    logic [9:0]  rem;
    logic [15:0] rad;
  } sq_t;

  function automatic sq_t sqrt_step(input sq_t a);
    logic [11:0] r;
    logic [11:0] t;
    sq_t         b;
    r     = {a.rem, a.rad[15:14]};
    t     = {2'b00, a.q, 2'b01};
    b.rad = {a.rad[13:0], 2'b00};
    if (r >= t) begin
      b.rem = 10'(r - t);
      b.q   = {a.q[6:0], 1'b1};
    end else begin
      b.rem = r[9:0];
      b.q   = {a.q[6:0], 1'b0};
    end
    return b;
  endfunction

  logic               en;
  logic signed [11:0] gx_acc, gy_acc;

  logic               g_vld_r, g_last_r;
  logic signed [10:0] gx_r, gy_r;
  logic signed [21:0] sqx, sqy;

  logic               p_vld_r, p_last_r;
  logic [19:0]        px_r, py_r;
  logic [20:0]        sum;

  logic               sq_vld_r  [SQ_STEPS+1];
  logic               sq_last_r [SQ_STEPS+1];
  logic               sq_sat_r  [SQ_STEPS+1];
  sq_t                sq_d_r    [SQ_STEPS+1];

  logic               out_valid_r;
  logic [7:0]         out_magnitude_r;
  logic               out_last_r;
  logic [7:0]         root;
  logic               round_up;

  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && !q_empty;

  always_comb begin
    gx_acc = '0;
    gy_acc = '0;
    for (int k = 0; k < 9; k++) begin
      gx_acc = gx_acc + 12'(sem_pkg::KERN_X[k]) * $signed({4'b0000, q_data.tap[k]});
      gy_acc = gy_acc + 12'(sem_pkg::KERN_Y[k]) * $signed({4'b0000, q_data.tap[k]});
    end
  end

  assign sqx      = gx_r * gx_r;
  assign sqy      = gy_r * gy_r;
  assign sum      = 21'(px_r) + 21'(py_r);
  assign root     = sq_d_r[SQ_STEPS].q;
  assign round_up = sq_d_r[SQ_STEPS].rem > {2'b00, root};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r     <= 1'b0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= SQ_STEPS; k++) begin
        sq_vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      g_vld_r     <= q_pop;
      p_vld_r     <= g_vld_r;
      sq_vld_r[0] <= p_vld_r;
      for (int k = 0; k < SQ_STEPS; k++) begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
      out_valid_r <= sq_vld_r[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx_r         <= $signed(gx_acc[10:0]);
      gy_r         <= $signed(gy_acc[10:0]);
      g_last_r     <= q_data.last;
      px_r         <= sqx[19:0];
      py_r         <= sqy[19:0];
      p_last_r     <= g_last_r;
      sq_d_r[0]    <= '{q: 8'd0, rem: 10'd0, rad: sum[15:0]};
      sq_sat_r[0]  <= (sum >= SAT_LIMIT);
      sq_last_r[0] <= p_last_r;
      for (int k = 0; k < SQ_STEPS; k++) begin
        sq_d_r[k+1]    <= sqrt_step(sq_d_r[k]);
        sq_sat_r[k+1]  <= sq_sat_r[k];
        sq_last_r[k+1] <= sq_last_r[k];
      end
      out_magnitude_r <= sq_sat_r[SQ_STEPS] ? 8'hFF : root + 8'(round_up);
      out_last_r      <= sq_last_r[SQ_STEPS];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = out_magnitude_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

[rtl/core/sobel_edge_magnitude_top.sv]
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_top
// Streaming 3x3 Sobel edge magnitude over RGB pixels in raster order. Each
// pixel becomes luma (30R+59G+11B)/100, two luma rows live in one
// MAX_WIDTH x 16-bit row memory that is read when a pixel is taken and
// written when that pixel leaves the next stage, and the clamp-to-edge
// neighborhood goes through a
// QUEUE_DEPTH-entry queue into a back end that forms Gx and Gy, squares and
// sums them and takes a rounded square root, one bit per stage over eight
// stages, saturated at 255. One pixel or flush item is taken per clock as
// long as the result side does not stall; the result for a pixel belongs to
// the item taken frame_width+1 items later. Send frame_width+1 flush items
// after a frame; the final result carries out_last. A register write
// restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude_top #(
  parameter  int MAX_WIDTH   = sem_pkg::MAX_WIDTH_DEF,
  parameter  int QUEUE_DEPTH = sem_pkg::QUEUE_DEPTH_DEF,
  localparam int WID_W       = $clog2(MAX_WIDTH + 1)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_magnitude,
  output logic        out_last
);

  function automatic logic [WID_W-1:0] eff_width(input logic [11:0] fw);
    return (fw == 12'd0) ? WID_W'(1) :
           (32'(fw) > MAX_WIDTH) ? WID_W'(MAX_WIDTH) : WID_W'(fw);
  endfunction

  logic              cfg_wr;
  sem_pkg::reg_idx_t cfg_idx;
  logic [11:0]       frame_width_r;
  logic [15:0]       frame_height_r;
  logic [WID_W-1:0]  width_eff_r;
  logic [15:0]       height_eff_r;

  logic              q_push, q_full, q_pop, q_empty;
  sem_pkg::nbhd_t    q_push_data, q_pop_data;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = sem_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 12'(sem_pkg::FRAME_WIDTH_RST);
      frame_height_r <= 16'(sem_pkg::FRAME_HEIGHT_RST);
      width_eff_r    <= eff_width(12'(sem_pkg::FRAME_WIDTH_RST));
      height_eff_r   <= 16'(sem_pkg::FRAME_HEIGHT_RST);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sem_pkg::REG_FRAME_WIDTH: begin
          frame_width_r <= pwdata[11:0];
          width_eff_r   <= eff_width(pwdata[11:0]);
        end
        sem_pkg::REG_FRAME_HEIGHT: begin
          frame_height_r <= pwdata[15:0];
          height_eff_r   <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
        end
        default: begin
          frame_width_r <= frame_width_r;
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      sem_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_r);
      sem_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_r);
      default:                   prdata = '0;
    endcase
  end

  sem_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_wr),
    .width_eff  (width_eff_r),
    .height_eff (height_eff_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .q_push     (q_push),
    .q_data     (q_push_data),
    .q_full     (q_full)
  );

  sem_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  sem_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_pop_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_magnitude (out_magnitude),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

[rtl/core/sem_port_checker.sv]
// ----------------------------------------------------------------------------
// sem_port_checker
// Port-level checks of the Sobel edge magnitude block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_port_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_magnitude,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_magnitude) && $stable(out_last))
    else $error("result changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without a stalled result side");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("channels not idle after reset");

  a_valid_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_stall))
    else $error("input stall unknown");

endmodule

bind sobel_edge_magnitude_top sem_port_checker u_port_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_magnitude (out_magnitude),
  .out_last      (out_last)
);

`default_nettype wire

[tb/sv/sobel_magnitude_checker.sv]
// ----------------------------------------------------------------------------
// sobel_magnitude_checker
// Watches the register port and both stream channels of the Sobel edge
// magnitude block. Each input transfer advances a private luma line store
// and 3x3 window and predicts the magnitude and last flag it releases; each
// output transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sobel_magnitude_checker
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  input  logic       pready,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_opcode,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_magnitude,
  input  logic       out_last,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SOBEL_X [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
  localparam int SOBEL_Y [9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

  typedef struct packed {
    logic [7:0] magnitude;
    logic       last;
  } gradient_t;

  logic [11:0] width_reg;
  logic [15:0] height_reg;
  logic [7:0]  luma_two_up [MAX_WIDTH];
  logic [7:0]  luma_one_up [MAX_WIDTH];
  logic [7:0]  window [9];
  int unsigned in_col;
  int unsigned in_row;
  int unsigned out_col;
  int unsigned out_row;
  int          mismatches;
  gradient_t   expected_gradients [$];
  gradient_t   want;

  initial begin
    mismatches = 0;
  end

  task automatic restart_frame();
    for (int k = 0; k < 9; k++) begin
      window[k] = 8'd0;
    end
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endtask

  task automatic slide_window(input logic [7:0] top, input logic [7:0] mid,
                              input logic [7:0] bot);
    logic [7:0] column [3];
    column[0] = top;
    column[1] = mid;
    column[2] = bot;
    for (int k = 0; k < 3; k++) begin
      window[k*3]     = window[k*3 + 1];
      window[k*3 + 1] = window[k*3 + 2];
      window[k*3 + 2] = column[k];
    end
  endtask

  function automatic logic [7:0] gradient_at(input int unsigned h, input int mid);
    int          cols [3];
    int          rows [3];
    int          gx;
    int          gy;
    int          lum;
    int          b;
    int unsigned s;
    int unsigned q;
    int unsigned t;
    cols[0] = (out_col == 0) ? mid : mid - 1;
    cols[1] = mid;
    cols[2] = 2;
    rows[0] = (out_row == 0) ? 1 : 0;
    rows[1] = 1;
    rows[2] = (out_row + 1 >= h) ? 1 : 2;
    gx = 0;
    gy = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        lum = int'(window[rows[i]*3 + cols[j]]);
        gx += lum * SOBEL_X[i*3 + j];
        gy += lum * SOBEL_Y[i*3 + j];
      end
    end
    s = gx * gx + gy * gy;
    q = 0;
    for (b = 11; b >= 0; b--) begin
      t = q | (32'd1 << b);
      if (t * t <= s) begin
        q = t;
      end
    end
    if (s - q * q > q) begin
      q++;
    end
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  task automatic predict_magnitude(input opcode_t op, input logic [7:0] r,
                                   input logic [7:0] g, input logic [7:0] b);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned weighted;
    logic [7:0]  luma;
    logic [7:0]  up2;
    logic [7:0]  up1;
    logic [7:0]  mag;
    bit          fire;
    gradient_t   res;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg == 0) ? 1 : height_reg;
    luma = 8'd0;
    mag = 8'd0;
    if (op == OP_PIXEL) begin
      weighted = 30 * int'(r) + 59 * int'(g) + 11 * int'(b);
      luma = 8'(weighted / 100);
    end
    col = (in_col >= w) ? 0 : in_col;
    up2 = luma_two_up[col];
    up1 = luma_one_up[col];
    luma_two_up[col] = up1;
    luma_one_up[col] = luma;
    fire = (in_row >= 2 || (in_row == 1 && col >= 1)) && out_row < h;
    if (col == 0) begin
      if (fire) begin
        mag = gradient_at(h, 2);
      end
      slide_window(up2, up1, luma);
    end else begin
      slide_window(up2, up1, luma);
      if (fire) begin
        mag = gradient_at(h, 1);
      end
    end
    in_col = col + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (fire) begin
      res.magnitude = mag;
      res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
      expected_gradients.push_back(res);
      if (res.last) begin
        restart_frame();
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = 12'(FRAME_WIDTH_RST);
      height_reg = 16'(FRAME_HEIGHT_RST);
      for (int k = 0; k < MAX_WIDTH; k++) begin
        luma_two_up[k] = 8'd0;
        luma_one_up[k] = 8'd0;
      end
      restart_frame();
      expected_gradients.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (reg_idx_t'(paddr[2]) == REG_FRAME_WIDTH) begin
          width_reg = pwdata[11:0];
        end else begin
          height_reg = pwdata[15:0];
        end
        restart_frame();
      end
      if (in_valid && !in_stall) begin
        predict_magnitude(opcode_t'(in_opcode), in_red, in_green, in_blue);
      end
      if (out_valid && !out_stall) begin
        if (expected_gradients.size() == 0) begin
          $error("unexpected result: magnitude %0d last %0d", out_magnitude, out_last);
          mismatches++;
        end else begin
          want = expected_gradients.pop_front();
          if (out_magnitude !== want.magnitude) begin
            $error("magnitude: expected %0d, actual %0d", want.magnitude, out_magnitude);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_last);
            mismatches++;
          end
        end
      end
    end
    errors <= mismatches;
    pending <= expected_gradients.size();
  end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives the Sobel edge magnitude block with frames of RGB pixels followed
// by flush transfers: a short directed set of border and flush cases, the
// widest and tallest frame settings, then random frames with noise,
// truncated frames, random gaps on both channels and one long output hold.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sem_pkg::*;

  localparam int RANDOM_ITEMS  = 620;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = OP_PIXEL;
  logic [7:0]  in_red = 8'd0;
  logic [7:0]  in_green = 8'd0;
  logic [7:0]  in_blue = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_magnitude;
  logic        out_last;

  int          fail_count;
  int          expected_left;
  int          items_sent = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;
  logic        hold_req = 1'b0;

  sobel_edge_magnitude_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_magnitude (out_magnitude),
    .out_last      (out_last)
  );

  sobel_magnitude_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_magnitude (out_magnitude),
    .out_last      (out_last),
    .errors        (fail_count),
    .pending       (expected_left)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int  hold_left;
    bit  hold_started;
    hold_left = 0;
    hold_started = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 8);
      end
    end
  end

  function automatic logic [7:0] rand_channel();
    if ($urandom_range(3) == 0) begin
      return $urandom_range(1) ? 8'd255 : 8'd0;
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic send_item(input opcode_t op, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    if (!quiet) begin
      while ($urandom_range(99) < 8) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_frame(input int unsigned w, input int unsigned h,
                            input int unsigned pixels, input bit noisy);
    int unsigned n;
    for (n = 0; n < pixels; n++) begin
      if (noisy && $urandom_range(19) == 0) begin
        send_item(OP_FLUSH, rand_channel(), rand_channel(), rand_channel());
      end else begin
        send_item(OP_PIXEL, rand_channel(), rand_channel(), rand_channel());
      end
    end
    if (pixels == w * h) begin
      for (n = 0; n <= w; n++) begin
        if (noisy && $urandom_range(9) == 0) begin
          send_item(OP_PIXEL, rand_channel(), rand_channel(), rand_channel());
        end else begin
          send_item(OP_FLUSH, rand_channel(), rand_channel(), rand_channel());
        end
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(input logic [31:0] width_val, input logic [31:0] height_val);
    reg_idx_t idx;
    for (int k = 0; k < 2; k++) begin
      idx = (k == 0) ? REG_FRAME_WIDTH : REG_FRAME_HEIGHT;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= (k == 0) ? width_val : height_val;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int unsigned wv;
    int unsigned hv;
    int unsigned w;
    int unsigned h;
    int unsigned area;
    int          random_start;
    bit          need_config;
    bit          noisy;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    drain_results();

    set_frame(32'h0000_F003, 32'd2);
    send_item(OP_PIXEL, 8'd255, 8'd0, 8'd0);
    send_item(OP_PIXEL, 8'd0, 8'd0, 8'd0);
    send_item(OP_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(OP_PIXEL, 8'd0, 8'd255, 8'd0);
    send_item(OP_FLUSH, 8'd255, 8'd255, 8'd255);
    send_item(OP_PIXEL, 8'd0, 8'd0, 8'd255);
    send_item(OP_FLUSH, 8'd0, 8'd0, 8'd0);
    send_item(OP_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(OP_FLUSH, 8'd0, 8'd0, 8'd0);
    send_item(OP_FLUSH, 8'd0, 8'd0, 8'd0);
    drain_results();

    set_frame(32'd0, 32'd0);
    send_item(OP_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(OP_FLUSH, 8'd0, 8'd0, 8'd0);
    send_item(OP_FLUSH, 8'd0, 8'd0, 8'd0);
    drain_results();

    set_frame(32'd1, 32'd3);
    send_item(OP_PIXEL, 8'd0, 8'd0, 8'd0);
    send_item(OP_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(OP_PIXEL, 8'd0, 8'd0, 8'd0);
    send_item(OP_FLUSH, 8'd0, 8'd0, 8'd0);
    send_item(OP_FLUSH, 8'd0, 8'd0, 8'd0);
    drain_results();

    set_frame(32'd4095, 32'd1);
    send_frame(2048, 1, 64, 1'b0);
    drain_results();

    set_frame(32'd2, 32'd65535);
    send_frame(2, 65535, 40, 1'b0);
    drain_results();

    hold_req <= 1'b1;
    random_start = items_sent;
    need_config = 1'b1;
    w = 1;
    h = 1;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      quiet = (items_sent - random_start >= 250) && (items_sent - random_start < 450);
      if (need_config || $urandom_range(3) == 0) begin
        case ($urandom_range(19))
          0:       wv = 0;
          1, 2, 3: wv = $urandom_range(24, 7);
          default: wv = $urandom_range(6, 1);
        endcase
        hv = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
        w = (wv == 0) ? 1 : wv;
        h = (hv == 0) ? 1 : hv;
        drain_results();
        set_frame(wv, hv);
      end
      area = w * h;
      noisy = ($urandom_range(4) == 0);
      if (area > 1 && $urandom_range(9) == 0) begin
        send_frame(w, h, $urandom_range(area - 1, 1), noisy);
        need_config = 1'b1;
      end else begin
        send_frame(w, h, area, noisy);
        need_config = 1'b0;
      end
    end
    quiet = 1'b0;
    drain_results();

    if (fail_count == 0 && expected_left == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/sem_pkg.sv
rtl/core/sem_queue.sv
rtl/core/sem_front.sv
rtl/core/sem_back.sv
rtl/core/sobel_edge_magnitude_top.sv
rtl/core/sem_port_checker.sv
tb/sv/sobel_magnitude_checker.sv
tb/sv/tb_top.sv
